[src/rfq_pkg.sv]
// shared types, constants and an index wrap helper for the reversible fifo queue
// no dependencies; imported by rfq_ctrl, rfq_out, rfq_checker and the top level
package rfq_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  localparam logic [1:0] MODE_ENQ = 2'd0;
  localparam logic [1:0] MODE_DEQ = 2'd1;
  localparam logic [1:0] MODE_REV = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data_out;
  } out_item_t;

  typedef struct packed {
    logic          we;
    logic          re;
    logic [AW-1:0] addr;
    logic [31:0]   wdata;
  } ram_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       rd;
  } rsp_info_t;

  // sum of an index and an offset, known to stay below twice the depth
  function automatic logic [AW-1:0] wrap_idx(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    if (s >= SW'(DEPTH)) begin
      r = s - SW'(DEPTH);
    end else begin
      r = s;
    end
    return r[AW-1:0];
  endfunction

endpackage

[src/rfq_ram.sv]
// generic single-port ram with registered read data
// no dependencies; holds the queue entries
module rfq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                          wdata,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/rfq_ctrl.sv]
// pointer, count and direction control; decodes one command per transaction
// depends on rfq_pkg; drives the ram request and the result info
module rfq_ctrl import rfq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  in_item_t  item,
  output ram_req_t  req,
  output rsp_info_t info
);

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          rev_r, rev_nxt;

  logic          full, empty;
  logic [AW-1:0] tail_idx, last_idx, head_inc, head_dec;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign tail_idx = wrap_idx(SW'(head_r) + SW'(count_r));
  assign last_idx = wrap_idx(SW'(head_r) + SW'(count_r) - SW'(1));
  assign head_inc = wrap_idx(SW'(head_r) + SW'(1));
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);

  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    rev_nxt     = rev_r;
    req.we      = 1'b0;
    req.re      = 1'b0;
    req.addr    = head_r;
    req.wdata   = item.value;
    info.status = ST_DONE;
    info.rd     = 1'b0;
    unique case (item.mode)
      MODE_ENQ: begin
        if (full) begin
          info.status = ST_FULL;
        end else if (!rev_r) begin
          req.we    = 1'b1;
          req.addr  = tail_idx;
          count_nxt = count_r + CW'(1);
        end else begin
          req.we    = 1'b1;
          req.addr  = head_dec;
          head_nxt  = head_dec;
          count_nxt = count_r + CW'(1);
        end
      end
      MODE_DEQ: begin
        if (empty) begin
          info.status = ST_EMPTY;
        end else if (!rev_r) begin
          req.re    = 1'b1;
          info.rd   = 1'b1;
          req.addr  = head_r;
          head_nxt  = head_inc;
          count_nxt = count_r - CW'(1);
        end else begin
          req.re    = 1'b1;
          info.rd   = 1'b1;
          req.addr  = last_idx;
          count_nxt = count_r - CW'(1);
        end
      end
      MODE_REV: begin
        if (empty) begin
          info.status = ST_EMPTY;
        end else begin
          rev_nxt = !rev_r;
        end
      end
      default: begin
      end
    endcase
    if (!accept) begin
      req.we = 1'b0;
      req.re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
    end else if (accept) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
    end
  end

endmodule

[src/rfq_out.sv]
// ram read stage and result register with stall handling
// depends on rfq_pkg; joins the result info with the ram read data
module rfq_out import rfq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  rsp_info_t info,
  input  logic [31:0] rdata,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      s1_valid_r;
  rsp_info_t s1_info_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      s1_adv;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = !rst_n || (s1_valid_r && !s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info_r <= info;
    end
    if (s1_adv) begin
      out_data_r.status   <= s1_info_r.status;
      out_data_r.data_out <= s1_info_r.rd ? rdata : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[src/reversible_fifo_queue.sv]
// top level of the reversible fifo queue
// depends on rfq_pkg, rfq_ctrl, rfq_ram and rfq_out
//
// channel  dir  handshake            payload
// in       in   in_valid / in_stall  in_data  (mode, value)
// out      out  out_valid / out_stall out_data (status, data_out)
//
// one command per cycle unless in_stall is high; a result is held in the read stage, then in the output register
// pointers, count and direction flag update at the accepting edge; the single
// ram port is written or read in that same edge and its read data is registered
// synchronous active-low reset clears pointers, count, flag and all valids
// in_stall is high during reset and otherwise only while a result waits in the
// output register under out_stall
module reversible_fifo_queue import rfq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic        accept;
  ram_req_t    req;
  rsp_info_t   info;
  logic [31:0] rdata;

  assign accept = in_valid && !in_stall;

  rfq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(accept),
    .item  (in_data),
    .req   (req),
    .info  (info)
  );

  rfq_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (req.we),
    .re   (req.re),
    .addr (req.addr),
    .wdata(req.wdata),
    .rdata(rdata)
  );

  rfq_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .info     (info),
    .rdata    (rdata),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

[src/rfq_checker.sv]
// port-level assertions for the reversible fifo queue, bound to the top level
// depends on rfq_pkg and reversible_fifo_queue
module rfq_checker import rfq_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_DONE |-> out_data.data_out == '0)
    else $error("failed command returned data");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && rst_n, 2))
    else $error("result without a transaction two cycles earlier");

endmodule

bind reversible_fifo_queue rfq_checker u_rfq_checker (.*);
